### rtl/ds_twr_distance_calculator_assert.svh
// ----------------------------------------------------------------------------
// ds twr distance calculator assertion macros
// shared property forms for the checker, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef DS_TWR_DISTANCE_CALCULATOR_ASSERT_SVH
`define DS_TWR_DISTANCE_CALCULATOR_ASSERT_SVH

// consequent in the same cycle
`define DSTWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define DSTWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg
// field widths, status codes and register indexes of the ranging calculator
// ----------------------------------------------------------------------------
`default_nettype none

package dstwr_pkg;

  localparam int TS_FIELD_W = 40;
  localparam int STATUS_W   = 3;
  localparam int FLIGHT_W   = 56;
  localparam int DIST_W     = 20;
  localparam int MAXF_W     = 40;
  localparam int MAXD_W     = 20;
  localparam int SCALE_W    = 32;
  localparam int SCALE_FRAC = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEG      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FLIGHT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIST     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK = 2'd2;

  localparam logic [MAXF_W-1:0]  RST_MAX_FLIGHT  = 40'd1000000000;
  localparam logic [MAXD_W-1:0]  RST_MAX_DIST    = 20'd1000000;
  localparam logic [SCALE_W-1:0] RST_MM_PER_TICK = 32'd78714737;

  typedef struct packed {
    logic zero_den;
    logic neg;
  } dstwr_flags_t;

endpackage

`default_nettype wire

### rtl/dstwr_ifs.sv
// ----------------------------------------------------------------------------
// dstwr channel interfaces
// timestamp input, result output and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface dstwr_in_if import dstwr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TS_FIELD_W-1:0] poll_tx_time;
  logic [TS_FIELD_W-1:0] poll_rx_time;
  logic [TS_FIELD_W-1:0] resp_tx_time;
  logic [TS_FIELD_W-1:0] resp_rx_time;
  logic [TS_FIELD_W-1:0] final_tx_time;
  logic [TS_FIELD_W-1:0] final_rx_time;
  modport source (output valid, poll_tx_time, poll_rx_time, resp_tx_time,
                  resp_rx_time, final_tx_time, final_rx_time, input ready);
  modport sink (input valid, poll_tx_time, poll_rx_time, resp_tx_time,
                resp_rx_time, final_tx_time, final_rx_time, output ready);
endinterface

interface dstwr_out_if import dstwr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FLIGHT_W-1:0] flight_ticks_q16;
  logic [DIST_W-1:0]   range_mm;
  modport source (output valid, status, flight_ticks_q16, range_mm, input ready);
  modport sink (input valid, status, flight_ticks_q16, range_mm, output ready);
endinterface

interface dstwr_cfg_if import dstwr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/dstwr_front.sv
// ----------------------------------------------------------------------------
// dstwr_front
// intervals, split products, exact numerator with sign flag and denominator
// ----------------------------------------------------------------------------
`default_nettype none

module dstwr_front import dstwr_pkg::*; #(
  parameter int TSB = 40,
  parameter int FB  = 16,
  parameter int NW  = 2 * TSB + FB,
  parameter int DW  = TSB + 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  i_valid,
  output      logic                  i_ready,
  input  wire logic [TS_FIELD_W-1:0] poll_tx,
  input  wire logic [TS_FIELD_W-1:0] poll_rx,
  input  wire logic [TS_FIELD_W-1:0] resp_tx,
  input  wire logic [TS_FIELD_W-1:0] resp_rx,
  input  wire logic [TS_FIELD_W-1:0] final_tx,
  input  wire logic [TS_FIELD_W-1:0] final_rx,
  output      logic                  o_valid,
  input  wire logic                  o_ready,
  output      logic [NW-1:0]         o_nq,
  output      logic [DW-1:0]         o_den,
  output      dstwr_flags_t          o_flags
);

  localparam int HL = TSB / 2;
  localparam int HH = TSB - HL;
  localparam int PW = 2 * TSB;

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  logic [TSB-1:0] ra_r, rb_r, da_r, db_r;
  logic [TSB+HL-1:0] prl_r, pdl_r;
  logic [TSB+HH-1:0] prh_r, pdh_r;
  logic [DW-1:0] den2_r, den3_r, den4_r;
  logic [PW-1:0] pr_r, pd_r;
  logic [PW-1:0] pr_nxt, pd_nxt;
  logic [NW-1:0] nq_r;
  dstwr_flags_t flags_r;

  assign adv4 = !v4_r || o_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign i_ready = adv1;

  assign pr_nxt = PW'(prl_r) + (PW'(prh_r) << HL);
  assign pd_nxt = PW'(pdl_r) + (PW'(pdh_r) << HL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= i_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && i_valid) begin
      ra_r <= TSB'(resp_rx) - TSB'(poll_tx);
      rb_r <= TSB'(final_rx) - TSB'(resp_tx);
      da_r <= TSB'(final_tx) - TSB'(resp_rx);
      db_r <= TSB'(resp_tx) - TSB'(poll_rx);
    end
    if (adv2 && v1_r) begin
      prl_r  <= (TSB+HL)'(ra_r) * (TSB+HL)'(rb_r[HL-1:0]);
      prh_r  <= (TSB+HH)'(ra_r) * (TSB+HH)'(rb_r[TSB-1:HL]);
      pdl_r  <= (TSB+HL)'(da_r) * (TSB+HL)'(db_r[HL-1:0]);
      pdh_r  <= (TSB+HH)'(da_r) * (TSB+HH)'(db_r[TSB-1:HL]);
      den2_r <= DW'(ra_r) + DW'(rb_r) + DW'(da_r) + DW'(db_r);
    end
    if (adv3 && v2_r) begin
      pr_r   <= pr_nxt;
      pd_r   <= pd_nxt;
      den3_r <= den2_r;
    end
    if (adv4 && v3_r) begin
      nq_r             <= NW'(pr_r - pd_r) << FB;
      flags_r.neg      <= pr_r < pd_r;
      flags_r.zero_den <= den3_r == '0;
      den4_r           <= den3_r;
    end
  end

  assign o_valid = v4_r;
  assign o_nq    = nq_r;
  assign o_den   = den4_r;
  assign o_flags = flags_r;

endmodule

`default_nettype wire

### rtl/dstwr_div_cell.sv
// ----------------------------------------------------------------------------
// dstwr_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module dstwr_div_cell import dstwr_pkg::*; #(
  parameter int NW = 96,
  parameter int DW = 42
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          i_valid,
  output      logic          i_ready,
  input  wire logic [NW-1:0] i_nq,
  input  wire logic [DW-1:0] i_rem,
  input  wire logic [DW-1:0] i_den,
  input  wire dstwr_flags_t  i_flags,
  output      logic          o_valid,
  input  wire logic          o_ready,
  output      logic [NW-1:0] o_nq,
  output      logic [DW-1:0] o_rem,
  output      logic [DW-1:0] o_den,
  output      dstwr_flags_t  o_flags
);

  logic          v_r;
  logic          adv;
  logic [NW-1:0] nq_r;
  logic [DW-1:0] rem_r, den_r;
  dstwr_flags_t  flags_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   rem_nxt;

  assign adv     = !v_r || o_ready;
  assign i_ready = adv;
  assign trial   = {i_rem, i_nq[NW-1]};
  assign ge      = trial >= {1'b0, i_den};
  assign rem_nxt = ge ? trial - {1'b0, i_den} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && i_valid) begin
      nq_r    <= {i_nq[NW-2:0], ge};
      rem_r   <= rem_nxt[DW-1:0];
      den_r   <= i_den;
      flags_r <= i_flags;
    end
  end

  assign o_valid = v_r;
  assign o_nq    = nq_r;
  assign o_rem   = rem_r;
  assign o_den   = den_r;
  assign o_flags = flags_r;

endmodule

`default_nettype wire

### rtl/dstwr_back.sv
// ----------------------------------------------------------------------------
// dstwr_back
// flight limit check, split distance product, range check, output register
// ----------------------------------------------------------------------------
`default_nettype none

module dstwr_back import dstwr_pkg::*; #(
  parameter int TSB = 40,
  parameter int FB  = 16,
  parameter int NW  = 2 * TSB + FB,
  parameter int DW  = TSB + 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                i_valid,
  output      logic                i_ready,
  input  wire logic [NW-1:0]       i_quo,
  input  wire logic [DW-1:0]       i_rem,
  input  wire dstwr_flags_t        i_flags,
  input  wire logic [MAXF_W-1:0]   max_flight,
  input  wire logic [MAXD_W-1:0]   max_dist,
  input  wire logic [SCALE_W-1:0]  mm_per_tick,
  output      logic                o_valid,
  input  wire logic                o_ready,
  output      logic [STATUS_W-1:0] o_status,
  output      logic [FLIGHT_W-1:0] o_flight,
  output      logic [DIST_W-1:0]   o_dist
);

  localparam int LW  = MAXF_W + FB;
  localparam int QH  = (LW + 1) / 2;
  localparam int QU  = LW - QH;
  localparam int PW  = LW + SCALE_W;
  localparam int SH  = FB + SCALE_FRAC;
  localparam int DXW = PW - SH;

  logic v1_r, v2_r;
  logic adv1, adv2;

  logic [LW-1:0] ql;
  logic [LW-1:0] limit;
  logic          over;

  logic [STATUS_W-1:0]   st1_r;
  logic [LW-1:0]         ql_r;
  logic [QH+SCALE_W-1:0] pl_r;
  logic [QU+SCALE_W-1:0] ph_r;

  logic [PW-1:0]       prod;
  logic [DXW-1:0]      mm_full;
  logic [STATUS_W-1:0] st_nxt;

  logic [STATUS_W-1:0] st_r;
  logic [FLIGHT_W-1:0] flight_r;
  logic [DIST_W-1:0]   dist_r;

  assign adv2    = !v2_r || o_ready;
  assign adv1    = !v1_r || adv2;
  assign i_ready = adv1;

  assign ql    = i_quo[LW-1:0];
  assign limit = LW'(max_flight) << FB;
  assign over  = (|i_quo[NW-1:LW]) || (ql > limit) || ((ql == limit) && (i_rem != '0));

  assign prod    = PW'(pl_r) + (PW'(ph_r) << QH);
  assign mm_full = prod[PW-1:SH];

  always_comb begin
    st_nxt = st1_r;
    if (st1_r == ST_OK && ((mm_full >> DIST_W) != '0 || mm_full[DIST_W-1:0] > max_dist)) begin
      st_nxt = ST_DIST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= i_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && i_valid) begin
      if (i_flags.zero_den) begin
        st1_r <= ST_ZERO_DEN;
      end else if (i_flags.neg) begin
        st1_r <= ST_NEG;
      end else if (over) begin
        st1_r <= ST_FLIGHT;
      end else begin
        st1_r <= ST_OK;
      end
      ql_r <= ql;
      pl_r <= (QH+SCALE_W)'(ql[QH-1:0]) * (QH+SCALE_W)'(mm_per_tick);
      ph_r <= (QU+SCALE_W)'(ql[LW-1:QH]) * (QU+SCALE_W)'(mm_per_tick);
    end
    if (adv2 && v1_r) begin
      st_r <= st_nxt;
      if (st_nxt == ST_OK) begin
        flight_r <= FLIGHT_W'(ql_r);
        dist_r   <= mm_full[DIST_W-1:0];
      end else begin
        flight_r <= '0;
        dist_r   <= '0;
      end
    end
  end

  assign o_valid  = v2_r;
  assign o_status = st_r;
  assign o_flight = flight_r;
  assign o_dist   = dist_r;

endmodule

`default_nettype wire

### rtl/ds_twr_distance_calculator.sv
// ----------------------------------------------------------------------------
// ds_twr_distance_calculator
// asymmetric double-sided two-way ranging: flight time and distance
// ----------------------------------------------------------------------------
// Takes one word of six timestamps per cycle unless the output stalls, and
// returns one result word per input word, in order, through four front
// stages, one cell per quotient bit of the divider chain, and two back stages
// ending in the output register. Throughput is set by the divider chain,
// where each cell resolves one quotient bit and hands its partial result to
// the next cell. Registers are written through the cfg port, always ready;
// the user must write them only while idle: the block does not enforce it.
`default_nettype none

module ds_twr_distance_calculator import dstwr_pkg::*; #(
  parameter int TIMESTAMP_BITS = 40,
  parameter int FRACTION_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dstwr_in_if.sink    in_ch,
  dstwr_out_if.source out_ch,
  dstwr_cfg_if.sink   cfg_ch
);

  localparam int NW = 2 * TIMESTAMP_BITS + FRACTION_BITS;
  localparam int DW = TIMESTAMP_BITS + 2;

  logic [MAXF_W-1:0]  max_flight_r;
  logic [MAXD_W-1:0]  max_dist_r;
  logic [SCALE_W-1:0] mm_per_tick_r;

  logic         c_valid [0:NW];
  logic         c_ready [0:NW];
  logic [NW-1:0] c_nq   [0:NW];
  logic [DW-1:0] c_rem  [0:NW];
  logic [DW-1:0] c_den  [0:NW];
  dstwr_flags_t c_flags [0:NW];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_flight_r  <= RST_MAX_FLIGHT;
      max_dist_r    <= RST_MAX_DIST;
      mm_per_tick_r <= RST_MM_PER_TICK;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MAX_FLIGHT:  max_flight_r  <= cfg_ch.data[MAXF_W-1:0];
        REG_MAX_DIST:    max_dist_r    <= cfg_ch.data[MAXD_W-1:0];
        REG_MM_PER_TICK: mm_per_tick_r <= cfg_ch.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  dstwr_front #(.TSB(TIMESTAMP_BITS), .FB(FRACTION_BITS), .NW(NW), .DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (in_ch.valid),
    .i_ready  (in_ch.ready),
    .poll_tx  (in_ch.poll_tx_time),
    .poll_rx  (in_ch.poll_rx_time),
    .resp_tx  (in_ch.resp_tx_time),
    .resp_rx  (in_ch.resp_rx_time),
    .final_tx (in_ch.final_tx_time),
    .final_rx (in_ch.final_rx_time),
    .o_valid  (c_valid[0]),
    .o_ready  (c_ready[0]),
    .o_nq     (c_nq[0]),
    .o_den    (c_den[0]),
    .o_flags  (c_flags[0])
  );

  assign c_rem[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    dstwr_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (c_valid[i]),
      .i_ready (c_ready[i]),
      .i_nq    (c_nq[i]),
      .i_rem   (c_rem[i]),
      .i_den   (c_den[i]),
      .i_flags (c_flags[i]),
      .o_valid (c_valid[i+1]),
      .o_ready (c_ready[i+1]),
      .o_nq    (c_nq[i+1]),
      .o_rem   (c_rem[i+1]),
      .o_den   (c_den[i+1]),
      .o_flags (c_flags[i+1])
    );
  end

  dstwr_back #(.TSB(TIMESTAMP_BITS), .FB(FRACTION_BITS), .NW(NW), .DW(DW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .i_valid     (c_valid[NW]),
    .i_ready     (c_ready[NW]),
    .i_quo       (c_nq[NW]),
    .i_rem       (c_rem[NW]),
    .i_flags     (c_flags[NW]),
    .max_flight  (max_flight_r),
    .max_dist    (max_dist_r),
    .mm_per_tick (mm_per_tick_r),
    .o_valid     (out_ch.valid),
    .o_ready     (out_ch.ready),
    .o_status    (out_ch.status),
    .o_flight    (out_ch.flight_ticks_q16),
    .o_dist      (out_ch.range_mm)
  );

  // unused: divisor leaving the last cell
  logic unused_den;
  assign unused_den = ^c_den[NW];

endmodule

`default_nettype wire

### rtl/dstwr_checker.sv
// ----------------------------------------------------------------------------
// dstwr_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ds_twr_distance_calculator_assert.svh"

module dstwr_checker import dstwr_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [FLIGHT_W-1:0] out_flight,
  input wire logic [DIST_W-1:0]   out_dist
);

  `DSTWR_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped")
  `DSTWR_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(out_status) && $stable(out_flight) && $stable(out_dist), "result changed while stalled")
  `DSTWR_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_flight == '0 && out_dist == '0, "error result carries values")
  `DSTWR_ASSERT_NOW(a_zero_flight, out_valid && out_status == ST_OK && out_flight == '0, out_dist == '0, "distance without flight")

endmodule

bind ds_twr_distance_calculator dstwr_checker u_dstwr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_flight (out_ch.flight_ticks_q16),
  .out_dist   (out_ch.range_mm)
);

`default_nettype wire
